// ===== design/vlcd_pkg.sv =====
`timescale 1ns / 1ps
package vlcd_pkg;

  localparam int unsigned CpWidth = 21;

  // Lead byte classes
  localparam logic [7:0] LeadMultiMin = 8'hC0;
  localparam logic [7:0] EscapeByte   = 8'hFE;
  localparam logic [7:0] RangeByte    = 8'hFF;

  // Two-byte forms
  localparam logic [15:0] ThreeByteMin = 16'hEBC0;
  localparam logic [15:0] TwoByteBase  = 16'hBF40;

  // Three-byte mapping bounds and offsets
  localparam logic [23:0] Bound1    = 24'hEC7080;
  localparam logic [23:0] Bound2    = 24'hEC8E50;
  localparam logic [23:0] Bound3    = 24'hFC903E;
  localparam logic [23:0] Offset1   = 24'hEB9380;
  localparam logic [23:0] Offset2   = 24'hEB9080;
  localparam logic [23:0] Offset3   = 24'hEB9060;
  localparam logic [23:0] Offset4   = 24'hEB903E;
  localparam logic [16:0] PlaneSpan = 17'h0FFFE;

  typedef enum logic [1:0] {
    ST_CHAR   = 2'd0,
    ST_ESCAPE = 2'd1,
    ST_RANGE  = 2'd2,
    ST_ERROR  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    HOLD_IDLE = 3'b001,
    HOLD_LEAD = 3'b010,
    HOLD_PAIR = 3'b100
  } hold_e;

  typedef struct packed {
    logic               valid;
    logic [CpWidth-1:0] codepoint;
    status_e            status;
  } result_t;

endpackage

// ===== design/vlcd_three_map.sv =====
`timescale 1ns / 1ps
module vlcd_three_map (
  input  logic [23:0] value_i,
  output logic [vlcd_pkg::CpWidth-1:0] codepoint_o
);
  import vlcd_pkg::*;

  logic [23:0] diff1;
  logic [23:0] diff2;
  logic [23:0] diff4;
  logic [23:0] w;
  logic [7:0]  q0;
  logic [16:0] r0;
  logic [8:0]  q;
  logic [23:0] adj;

  always_comb begin
    diff1 = value_i - Offset1;
    diff2 = value_i - Offset2;
    diff4 = value_i - Offset4;
    w     = value_i - Offset3;
    // w / 0xFFFE: estimate with w >> 16, remainder stays below twice the divisor
    q0    = w[23:16];
    r0    = {1'b0, w[15:0]} + {8'd0, q0, 1'b0};
    q     = {1'b0, q0} + {8'd0, (r0 >= PlaneSpan)};
    adj   = w + {14'd0, q, 1'b0};
    if (value_i < Bound1) begin
      codepoint_o = diff1[CpWidth-1:0];
    end else if (value_i < Bound2) begin
      codepoint_o = diff2[CpWidth-1:0];
    end else if (value_i < Bound3) begin
      codepoint_o = adj[CpWidth-1:0];
    end else begin
      codepoint_o = diff4[CpWidth-1:0];
    end
  end

endmodule

// ===== design/vlcd_decode.sv =====
`timescale 1ns / 1ps
module vlcd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic              line_start_i,
  input  logic              escape_allowed_i,
  output vlcd_pkg::result_t result_o
);
  import vlcd_pkg::*;

  hold_e       state_q, state_d;
  logic [15:0] partial_q, partial_d;
  logic [15:0] pair;
  logic [15:0] two_cp;
  logic [CpWidth-1:0] three_cp;

  assign pair   = {partial_q[7:0], data_byte_i};
  assign two_cp = pair - TwoByteBase;

  vlcd_three_map u_map (
    .value_i     ({partial_q, data_byte_i}),
    .codepoint_o (three_cp)
  );

  always_comb begin
    state_d   = HOLD_IDLE;
    partial_d = '0;
    result_o  = '{valid: 1'b0, codepoint: '0, status: ST_CHAR};
    case (state_q)
      HOLD_LEAD: begin
        if (pair < ThreeByteMin) begin
          result_o.valid     = 1'b1;
          result_o.codepoint = {{(CpWidth-16){1'b0}}, two_cp};
        end else begin
          partial_d = pair;
          state_d   = HOLD_PAIR;
        end
      end
      HOLD_PAIR: begin
        result_o.valid     = 1'b1;
        result_o.codepoint = three_cp;
      end
      default: begin
        if (data_byte_i < LeadMultiMin) begin
          result_o.valid     = 1'b1;
          result_o.codepoint = {{(CpWidth-8){1'b0}}, data_byte_i};
        end else if (data_byte_i == EscapeByte) begin
          result_o.valid  = 1'b1;
          result_o.status = escape_allowed_i ? ST_ESCAPE : ST_ERROR;
        end else if (data_byte_i == RangeByte) begin
          result_o.valid  = 1'b1;
          result_o.status = line_start_i ? ST_RANGE : ST_ERROR;
        end else begin
          partial_d = {8'd0, data_byte_i};
          state_d   = HOLD_LEAD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= HOLD_IDLE;
      partial_q <= '0;
    end else if (fire_i) begin
      state_q   <= state_d;
      partial_q <= partial_d;
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("hold state not one-hot");

  a_pair_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == HOLD_PAIR) |-> (result_o.valid && result_o.status == ST_CHAR))
    else $error("third byte did not complete a character");

  a_pair_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && state_q == HOLD_PAIR) |=> (state_q == HOLD_IDLE))
    else $error("decoder did not return to idle after third byte");

  a_prefix_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.status != ST_CHAR) |-> (result_o.codepoint == '0))
    else $error("non-character status with nonzero codepoint");
`endif

endmodule

// ===== design/variable_length_codepoint_decoder.sv =====
`timescale 1ns / 1ps
// A multi-byte form yields its result on its final byte, via the input and output registers.
// Throughput: one byte per cycle unless a full output stage stalls the input stage.
// Cycle time is set by the three-byte offset map and its divide-by-0xFFFE correction.
// Reset (rst_ni low, asynchronous): both stages empty, decoder idle with no form in progress.
module variable_length_codepoint_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [0] line_start, [1] escape_allowed
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] codepoint, [23:21] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import vlcd_pkg::*;

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_sol_q;
  logic               in_esc_q;
  logic               out_valid_q;
  logic [CpWidth-1:0] out_cp_q;
  status_e            out_status_q;
  result_t            result;
  logic               out_free;
  logic               advance;
  logic               fire;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  // hold the input stage only when it has a result and the output stage is full and not being taken
  assign advance         = !result.valid || out_free;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  vlcd_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .data_byte_i      (in_byte_q),
    .line_start_i     (in_sol_q),
    .escape_allowed_i (in_esc_q),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_sol_q  <= s_axis_tuser_i[0];
      in_esc_q  <= s_axis_tuser_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && result.valid) begin
      out_cp_q     <= result.codepoint;
      out_status_q <= result.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(24-CpWidth){1'b0}}, out_cp_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule
